FILE: rtl/led_bank_triangle_fader_assert.svh
// ----------------------------------------------------------------------------
// LED bank fader assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_BANK_TRIANGLE_FADER_ASSERT_SVH
`define LED_BANK_TRIANGLE_FADER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define LBTF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define LBTF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LBTF_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBTF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/lbtf_pkg.sv
// ----------------------------------------------------------------------------
// lbtf_pkg
// Shared types and constants of the LED bank triangle fader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbtf_pkg;

  // default bank size
  localparam int LED_COUNT_DEF = 16;

  // field widths
  localparam int LED_IDX_W = 4;
  localparam int LEVEL_W   = 8;
  localparam int PERIOD_W  = 7;
  localparam int COLOR_W   = 8;

  // fade bounds
  localparam logic [LEVEL_W-1:0] LEVEL_UPPER = 8'd150;
  localparam logic [LEVEL_W-1:0] LEVEL_LOWER = 8'd50;

  // x / 150 == (x * RECIP_M) >> RECIP_SHIFT for every 16-bit x
  localparam int              RECIP_SHIFT = 24;
  localparam logic [16:0]     RECIP_M     = 17'd111849;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // configuration register indexes
  localparam int              CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd2;

  // reset colors
  localparam logic [COLOR_W-1:0] RED_RST   = 8'd110;
  localparam logic [COLOR_W-1:0] GREEN_RST = 8'd30;
  localparam logic [COLOR_W-1:0] BLUE_RST  = 8'd0;

  // input request
  typedef struct packed {
    logic                 operation;
    logic [LED_IDX_W-1:0] led_index;
    logic [LEVEL_W-1:0]   load_level;
    logic [PERIOD_W-1:0]  load_period;
  } in_item_t;

  // result request
  typedef struct packed {
    logic [LED_IDX_W-1:0] led_number;
    logic [COLOR_W-1:0]   red_out;
    logic [COLOR_W-1:0]   green_out;
    logic [COLOR_W-1:0]   blue_out;
    logic                 last_led;
  } out_item_t;

endpackage

FILE: rtl/lbtf_stream_if.sv
// ----------------------------------------------------------------------------
// lbtf_stream_if
// Valid/ready stream channel carrying one request payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbtf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/led_bank_triangle_fader.sv
// ----------------------------------------------------------------------------
// led_bank_triangle_fader
// Bank of triangle-wave LED faders sharing one common color.
// Operation: a load request is written while idle. A tick request walks
//   every LED in turn, may stall on output back-pressure and takes no new
//   request until it ends; each LED runs a 7-step remainder loop and three
//   passes over the shared multiplier (product, then reciprocal scale).
// Reset: synchronous; colors return to their defaults and per-entry valid
//   bits clear, so every LED reads as level 0, rising, period 1, wait 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "led_bank_triangle_fader_assert.svh"

module led_bank_triangle_fader #(
  parameter int LED_COUNT = lbtf_pkg::LED_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lbtf_stream_if.sink                     in_chan,
  lbtf_stream_if.source                   out_chan,
  input  logic                            cfg_we,
  input  logic [lbtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbtf_pkg::COLOR_W-1:0]    cfg_wdata
);
  import lbtf_pkg::*;

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_LATCH = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_CH    = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  // color channel select
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic                falling;
    logic [LEVEL_W-1:0]  level;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] wait_cnt;
  } entry_t;

  localparam entry_t ENTRY_RST = '{falling: 1'b0, level: '0,
                                   period: 7'd1, wait_cnt: '0};

  logic [3:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    led_r;
  logic [1:0]          ch_r;
  logic [2:0]          bit_cnt_r;

  logic [COLOR_W-1:0]  red_cfg_r, green_cfg_r, blue_cfg_r;

  entry_t              mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld_r;
  entry_t              rd_r;
  logic                rd_vld_r;

  logic                falling_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] wait_r;
  logic [PERIOD_W-1:0] dvd_r;
  logic [PERIOD_W-1:0] rem_r;

  logic [32:0]         prod_r;
  logic [COLOR_W-1:0]  red_r, green_r, blue_r;

  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                in_fire;
  logic                load_ok;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  entry_t              cur;
  logic [PERIOD_W:0]   trial;
  logic                upd_fall;
  logic [LEVEL_W-1:0]  upd_level;
  entry_t              upd_entry;
  logic [15:0]         mul_a;
  logic [16:0]         mul_b;
  logic [COLOR_W-1:0]  ch_color;
  logic [8:0]          quot;
  logic [COLOR_W-1:0]  sat;
  logic                is_last;
  logic                emit_go;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign load_ok       = (32'(in_chan.data.led_index) < LED_COUNT);
  assign is_last       = (32'(led_r) == LED_COUNT - 1);
  assign emit_go       = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_cfg_r   <= RED_RST;
      green_cfg_r <= GREEN_RST;
      blue_cfg_r  <= BLUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RED:   red_cfg_r   <= cfg_wdata;
        CFG_GREEN: green_cfg_r <= cfg_wdata;
        CFG_BLUE:  blue_cfg_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // entry held for this LED, invalid entries read as reset value
  assign cur = rd_vld_r ? rd_r : ENTRY_RST;

  // fade step of the current LED
  always_comb begin
    upd_fall = falling_r;
    if (!falling_r && (level_r >= LEVEL_UPPER)) begin
      upd_fall = 1'b1;
    end else if (falling_r && (level_r <= LEVEL_LOWER)) begin
      upd_fall = 1'b0;
    end
    upd_level = upd_fall ? (level_r - 8'd1) : (level_r + 8'd1);
    upd_entry.period = period_r;
    if (rem_r == '0) begin
      upd_entry.falling  = upd_fall;
      upd_entry.level    = upd_level;
      upd_entry.wait_cnt = 7'd1;
    end else begin
      upd_entry.falling  = falling_r;
      upd_entry.level    = level_r;
      upd_entry.wait_cnt = wait_r + 7'd1;
    end
  end

  // memory write select: load in idle, write-back after update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = led_r;
    mem_wdata = upd_entry;
    if (in_fire && (in_chan.data.operation == OP_LOAD) && load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(in_chan.data.led_index);
      mem_wdata = '{falling: 1'b0, level: in_chan.data.load_level,
                    period: in_chan.data.load_period, wait_cnt: '0};
    end else if (state_r == S_UPD) begin
      mem_we = 1'b1;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r     <= mem[led_r];
    rd_vld_r <= vld_r[led_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_waddr] <= 1'b1;
    end
  end

  // remainder step: shift in one dividend bit, conditional subtract
  assign trial = {rem_r, dvd_r[PERIOD_W-1]};

  // shared multiplier operands
  always_comb begin
    case (ch_r)
      CH_RED:   ch_color = red_cfg_r;
      CH_GREEN: ch_color = green_cfg_r;
      CH_BLUE:  ch_color = blue_cfg_r;
      default:  ch_color = '0;
    endcase
    if (state_r == S_MUL2) begin
      mul_a = prod_r[15:0];
      mul_b = RECIP_M;
    end else begin
      mul_a = {8'd0, ch_color};
      mul_b = {9'd0, level_r};
    end
  end

  assign quot = prod_r[RECIP_SHIFT +: 9];
  assign sat  = (quot > 9'd255) ? 8'hFF : quot[7:0];

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_chan.data.operation == OP_TICK)) state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_LATCH;
      S_LATCH: state_nxt = S_MOD;
      S_MOD: begin
        if (bit_cnt_r == 3'd0) state_nxt = S_UPD;
      end
      S_UPD:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_CH;
      S_CH:   state_nxt = (ch_r == CH_BLUE) ? S_EMIT : S_MUL1;
      S_EMIT: begin
        if (emit_go) state_nxt = is_last ? S_IDLE : S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      led_r     <= '0;
      ch_r      <= CH_RED;
      bit_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE:  led_r     <= '0;
        S_LATCH: bit_cnt_r <= 3'(PERIOD_W - 1);
        S_MOD:   bit_cnt_r <= bit_cnt_r - 3'd1;
        S_UPD:   ch_r      <= CH_RED;
        S_CH:    ch_r      <= ch_r + 2'd1;
        S_EMIT: begin
          if (emit_go && !is_last) led_r <= led_r + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_LATCH: begin
        falling_r <= cur.falling;
        level_r   <= cur.level;
        period_r  <= (cur.period == '0) ? 7'd1 : cur.period;
        wait_r    <= cur.wait_cnt;
        dvd_r     <= cur.wait_cnt;
        rem_r     <= '0;
      end
      S_MOD: begin
        dvd_r <= {dvd_r[PERIOD_W-2:0], 1'b0};
        if (trial >= {1'b0, period_r}) begin
          rem_r <= PERIOD_W'(trial - {1'b0, period_r});
        end else begin
          rem_r <= trial[PERIOD_W-1:0];
        end
      end
      S_UPD: begin
        falling_r <= upd_entry.falling;
        level_r   <= upd_entry.level;
      end
      S_MUL1, S_MUL2: prod_r <= mul_a * mul_b;
      S_CH: begin
        case (ch_r)
          CH_RED:   red_r   <= sat;
          CH_GREEN: green_r <= sat;
          default:  blue_r  <= sat;
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.led_number <= LED_IDX_W'(led_r);
      out_data_r.red_out    <= red_r;
      out_data_r.green_out  <= green_r;
      out_data_r.blue_out   <= blue_r;
      out_data_r.last_led   <= is_last;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // checks
  `LBTF_ASSERT(a_rem_below_period, clk, rst_n, (state_r == S_UPD) |-> (rem_r < period_r), "remainder not below period")
  `LBTF_ASSERT_NEVER(a_led_in_range, clk, rst_n, (state_r != S_IDLE) && (32'(led_r) >= LED_COUNT), "LED counter out of range")
  `LBTF_ASSERT(a_last_ends_tick, clk, rst_n, (emit_go && is_last) |=> (state_r == S_IDLE) && out_valid_r && out_data_r.last_led, "tick did not end on last LED")
  `LBTF_ASSERT(a_tick_starts_at_zero, clk, rst_n, (state_r == S_IDLE) && (state_nxt == S_READ) |=> (led_r == '0), "tick did not start at LED zero")

endmodule

FILE: bench/tb_led_bank_triangle_fader.sv
// ----------------------------------------------------------------------------
// tb_led_bank_triangle_fader
// Self-checking bench for the LED bank fader. A short table of directed
// requests covers the level extremes, zero and longest periods, both
// operations and a write to the unused register index. Three random phases
// follow, each with its own color setting and handshake idling. A local
// fader model predicts every per-LED color, and a monitor compares each
// result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_bank_triangle_fader;
  import lbtf_pkg::*;

  localparam int LEDS           = LED_COUNT_DEF;
  localparam int TICK_CYCLES    = 1 + 20 * LEDS;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RAND_PER_PHASE = 97;
  localparam int DIRECTED_ROWS  = 22;

  // register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // one directed step: a request or a register write, with an optional
  // hand-computed color for one LED of a tick
  typedef struct {
    row_kind_e              kind;
    logic                   op;
    logic [LED_IDX_W-1:0]   index;
    logic [LEVEL_W-1:0]     level;
    logic [PERIOD_W-1:0]    period;
    logic [CFG_IDX_W-1:0]   reg_sel;
    logic [COLOR_W-1:0]     reg_val;
    bit                     typed;
    logic [LED_IDX_W-1:0]   typed_led;
    logic [3*COLOR_W-1:0]   typed_rgb;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;

  lbtf_stream_if #(.payload_t(in_item_t))  in_chan ();
  lbtf_stream_if #(.payload_t(out_item_t)) out_chan ();

  led_bank_triangle_fader #(
    .LED_COUNT(LEDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // fader model state
  logic [COLOR_W-1:0]  tint_red;
  logic [COLOR_W-1:0]  tint_green;
  logic [COLOR_W-1:0]  tint_blue;
  logic [LEVEL_W-1:0]  fader_level   [LEDS];
  bit                  fader_falling [LEDS];
  logic [PERIOD_W-1:0] fader_period  [LEDS];
  logic [PERIOD_W-1:0] fader_wait    [LEDS];

  out_item_t expected_colors[$];
  int        error_count   = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  directed_row_t directed_plan [DIRECTED_ROWS] = '{
    // tick straight out of reset: every LED at level 1, dark
    '{ROW_REQ, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b1, 4'd15, 24'h000000},
    '{ROW_CFG, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd255, 1'b0, 4'd0,  24'h0},
    '{ROW_CFG, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_GREEN,  8'd255, 1'b0, 4'd0,  24'h0},
    '{ROW_CFG, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_BLUE,   8'd255, 1'b0, 4'd0,  24'h0},
    '{ROW_CFG, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_UNUSED, 8'h5A,  1'b0, 4'd0,  24'h0},
    // top level, bottom level with zero period, upper bound, lower bound
    '{ROW_REQ, OP_LOAD, 4'd0,  8'd255, 7'd1,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_LOAD, 4'd1,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_LOAD, 4'd2,  8'd150, 7'd127, CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_LOAD, 4'd15, 8'd50,  7'd1,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    // level 255 turns, drops to 254 and saturates every channel
    '{ROW_REQ, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b1, 4'd0,  24'hFFFFFF},
    // long period: LED 2 holds at 149 and still emits
    '{ROW_REQ, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b1, 4'd2,  24'hFDFDFD},
    '{ROW_REQ, OP_LOAD, 4'd7,  8'd151, 7'd2,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_LOAD, 4'd8,  8'd49,  7'd5,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_LOAD, 4'd9,  8'd149, 7'd1,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_LOAD, 4'd5,  8'hAA,  7'h55,  CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_CFG, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_CFG, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_GREEN,  8'd128, 1'b0, 4'd0,  24'h0},
    '{ROW_CFG, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_BLUE,   8'd1,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    '{ROW_REQ, OP_TICK, 4'd0,  8'd0,   7'd0,   CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0},
    // tick with all unused fields set high
    '{ROW_REQ, OP_TICK, 4'hF,  8'hFF,  7'h7F,  CFG_RED,    8'd0,   1'b0, 4'd0,  24'h0}
  };

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // fader model
  // ---------------------------------------------------------------------

  function automatic void reset_faders();
    tint_red   = RED_RST;
    tint_green = GREEN_RST;
    tint_blue  = BLUE_RST;
    for (int n = 0; n < LEDS; n++) begin
      fader_level[n]   = '0;
      fader_falling[n] = 1'b0;
      fader_period[n]  = 7'd1;
      fader_wait[n]    = '0;
    end
  endfunction

  // tint * level / 150, truncated, clipped at full scale
  function automatic logic [COLOR_W-1:0] scale_channel(logic [COLOR_W-1:0] tint,
                                                       logic [LEVEL_W-1:0] level);
    int unsigned v;
    v = (int'(tint) * int'(level)) / int'(LEVEL_UPPER);
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic void load_fader(in_item_t req);
    // every 4-bit index is in range at 16 LEDs
    if (int'(req.led_index) < LEDS) begin
      fader_level[req.led_index]   = req.load_level;
      fader_period[req.led_index]  = req.load_period;
      fader_falling[req.led_index] = 1'b0;
      fader_wait[req.led_index]    = '0;
    end
  endfunction

  // step each LED whose wait count is a multiple of its period, then emit every LED
  function automatic void fade_bank_tick();
    out_item_t           res;
    logic [PERIOD_W-1:0] span;
    for (int n = 0; n < LEDS; n++) begin
      span = (fader_period[n] == '0) ? 7'd1 : fader_period[n];
      if (fader_wait[n] % span != 0) begin
        fader_wait[n] = fader_wait[n] + 1'b1;
      end else begin
        fader_wait[n] = 7'd1;
        // direction turns at the bounds before the move
        if (!fader_falling[n] && fader_level[n] >= LEVEL_UPPER)
          fader_falling[n] = 1'b1;
        else if (fader_falling[n] && fader_level[n] <= LEVEL_LOWER)
          fader_falling[n] = 1'b0;
        if (fader_falling[n])
          fader_level[n] = fader_level[n] - 1'b1;
        else
          fader_level[n] = fader_level[n] + 1'b1;
      end
      res.led_number = LED_IDX_W'(n);
      res.red_out    = scale_channel(tint_red, fader_level[n]);
      res.green_out  = scale_channel(tint_green, fader_level[n]);
      res.blue_out   = scale_channel(tint_blue, fader_level[n]);
      res.last_led   = (n == LEDS - 1);
      expected_colors.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // mostly ticks; loads favor the upper LEDs so the lower ones fade long
  // enough to turn at both bounds
  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    req.operation   = OP_TICK;
    req.led_index   = 4'($urandom);
    req.load_level  = 8'($urandom);
    req.load_period = 7'($urandom);
    if ($urandom_range(4) != 0) return req;
    req.operation = OP_LOAD;
    if ($urandom_range(3) != 0) req.led_index = 4'($urandom_range(15, 8));
    pick = $urandom_range(9);
    if (pick < 4)
      req.load_level = 8'($urandom_range(160, 140));
    else if (pick < 6)
      req.load_level = 8'($urandom_range(60, 40));
    pick = $urandom_range(9);
    if (pick < 6)
      req.load_period = 7'($urandom_range(3, 1));
    else if (pick == 6)
      req.load_period = '0;
    return req;
  endfunction

  // one request through the input channel; model updated on acceptance
  task automatic send_request(in_item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= req;
    do @(posedge clk); while (!in_chan.ready);
    if (req.operation == OP_LOAD)
      load_fader(req);
    else
      fade_bank_tick();
  endtask

  // register write once the bank has gone quiet
  task automatic write_color_reg(logic [CFG_IDX_W-1:0] sel, logic [COLOR_W-1:0] val);
    in_chan.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_RED:   tint_red   = val;
      CFG_GREEN: tint_green = val;
      CFG_BLUE:  tint_blue  = val;
      default: ;
    endcase
  endtask

  task automatic run_row(directed_row_t row);
    in_item_t req;
    int       pos;
    if (row.kind == ROW_CFG) begin
      write_color_reg(row.reg_sel, row.reg_val);
    end else begin
      req.operation   = row.op;
      req.led_index   = row.index;
      req.load_level  = row.level;
      req.load_period = row.period;
      send_request(req);
      // hand-computed color replaces the model's for that LED
      if (row.typed) begin
        pos = expected_colors.size() - LEDS + int'(row.typed_led);
        expected_colors[pos].red_out   = row.typed_rgb[23:16];
        expected_colors[pos].green_out = row.typed_rgb[15:8];
        expected_colors[pos].blue_out  = row.typed_rgb[7:0];
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_colors.size() == 0) begin
      $error("unexpected result for LED %0d", got.led_number);
      error_count++;
    end else begin
      want = expected_colors.pop_front();
      check_field("led_number", 8'(want.led_number), 8'(got.led_number));
      check_field("red_out", want.red_out, got.red_out);
      check_field("green_out", want.green_out, got.green_out);
      check_field("blue_out", want.blue_out, got.blue_out);
      check_field("last_led", 8'(want.last_led), 8'(got.last_led));
    end
  endtask

  // sample at the edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_result(out_chan.data);
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_RED;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    reset_faders();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0)
        for (int r = 0; r < DIRECTED_ROWS; r++) run_row(directed_plan[r]);

      // per-phase color, with full scale and zero on some channels
      write_color_reg(CFG_RED, (phase == 2) ? 8'd255 : 8'($urandom));
      write_color_reg(CFG_GREEN, (phase == 0) ? 8'd255 :
                                 (phase == 2) ? 8'd0 : 8'($urandom));
      write_color_reg(CFG_BLUE, (phase == 0) ? 8'd0 : 8'($urandom));
      write_color_reg(CFG_UNUSED, 8'($urandom));

      for (int k = 0; k < RAND_PER_PHASE; k++) send_request(random_request());
    end

    // drain, then watch for stray results
    in_chan.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (2 * TICK_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_colors.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
